/* rtl/vdib_pkg.sv */
// Shared request/response types and fixed constants for the vertex dedup index builder.
package vdib_pkg;

   localparam int KEY_FIELD_W = 64;
   localparam int IDX_OUT_W   = 8;
   localparam int NUM_KEYS    = 3;

   localparam logic OP_TRIANGLE = 1'b0;
   localparam logic OP_LINE     = 1'b1;

   typedef struct packed {
      logic                   operation;
      logic [KEY_FIELD_W-1:0] vertex_a;
      logic [KEY_FIELD_W-1:0] vertex_b;
      logic [KEY_FIELD_W-1:0] vertex_c;
   } req_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] index_a;
      logic [IDX_OUT_W-1:0] index_b;
      logic [IDX_OUT_W-1:0] index_c;
      logic [1:0]           new_entries;
      logic                 overflow;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic enable;
   } srch_ctl_type;

endpackage

/* rtl/vdib_cell.sv */
// One storage cell of the vertex ring: holds a key, loads from its neighbor or a write.
module vdib_cell #(
   parameter int KEY_W = 64
) (
   input  logic             clock,
   input  logic             shift_en,
   input  logic [KEY_W-1:0] shift_key,
   input  logic             wr_en,
   input  logic [KEY_W-1:0] wr_key,
   output logic [KEY_W-1:0] key
);

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;

   always_comb begin
      key_in = key_ff;
      if (wr_en) begin
         key_in = wr_key;
      end else if (shift_en) begin
         key_in = shift_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

/* rtl/vdib_match.sv */
// Compare head of the ring against the three query keys and keep the first hit of each.
module vdib_match #(
   parameter int KEY_W = 64,
   parameter int IDX_W = 8,
   parameter int CNT_W = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  vdib_pkg::srch_ctl_type ctl,
   input  logic [KEY_W-1:0]      head_key,
   input  logic [IDX_W-1:0]      pos,
   input  logic [CNT_W-1:0]      base,
   input  logic [KEY_W-1:0]      query [vdib_pkg::NUM_KEYS],
   output logic [vdib_pkg::NUM_KEYS-1:0] hit,
   output logic [IDX_W-1:0]      idx [vdib_pkg::NUM_KEYS]
);

   logic [vdib_pkg::NUM_KEYS-1:0] hit_ff;
   logic [vdib_pkg::NUM_KEYS-1:0] hit_in;
   logic [IDX_W-1:0]              idx_ff [vdib_pkg::NUM_KEYS];
   logic [IDX_W-1:0]              idx_in [vdib_pkg::NUM_KEYS];
   logic                          in_range;

   // only entries that existed before this request take part
   assign in_range = CNT_W'(pos) < base;

   always_comb begin
      for (int k = 0; k < vdib_pkg::NUM_KEYS; k++) begin
         hit_in[k] = hit_ff[k];
         idx_in[k] = idx_ff[k];
         if (ctl.clear) begin
            hit_in[k] = 1'b0;
         end else if (ctl.enable && in_range && !hit_ff[k] && (query[k] == head_key)) begin
            hit_in[k] = 1'b1;
            idx_in[k] = pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= '0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   assign hit = hit_ff;
   assign idx = idx_ff;

endmodule

/* rtl/vertex_dedup_index_builder_unit.sv */
// Top level of the vertex dedup index builder: key ring, search control and response.
//
// A request (triangle or line of vertex keys) is accepted when start is high and busy is low.
// The stored keys sit in a ring of TABLE_DEPTH cells that rotates one place per cycle past a
// single compare head during the search state, which runs one full turn of the ring; then the
// resolve state appends the new keys and loads the response. Busy stays high through both.
// The response, registered from the resolve state, is shown on rsp_data for exactly one cycle
// with rsp_valid high; the receiver cannot stall it, and busy is already low in that cycle so
// the next request may be accepted alongside it. No clearing pass is needed after reset:
// only entries below the entry count are ever searched.
module vertex_dedup_index_builder_unit #(
   parameter int TABLE_DEPTH = 256,
   parameter int KEY_BITS    = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vdib_pkg::req_type req_data,
   output logic              rsp_valid,
   output vdib_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W = KEY_BITS;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_SEARCH  = 2'd1;
   localparam logic [1:0] ST_RESOLVE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] base_ff;
   logic             op_ff;
   logic [KEY_W-1:0] key_ff [vdib_pkg::NUM_KEYS];
   logic             rsp_valid_ff;
   vdib_pkg::rsp_type rsp_ff, rsp_in;

   logic             accept;
   logic             st_search;
   logic             st_resolve;
   vdib_pkg::srch_ctl_type srch_ctl;

   logic [KEY_W-1:0] ring [TABLE_DEPTH];
   logic [vdib_pkg::NUM_KEYS-1:0] hit;
   logic [IDX_W-1:0] hit_idx [vdib_pkg::NUM_KEYS];

   logic [2:0]       miss;
   logic [1:0]       miss_cnt;
   logic             ovf;
   logic [KEY_W-1:0] new_key [4];
   logic [CNT_W-1:0] idx_a, idx_b, idx_c;

   assign accept     = start && !busy;
   assign busy       = state_ff != ST_IDLE;
   assign st_search  = state_ff == ST_SEARCH;
   assign st_resolve = state_ff == ST_RESOLVE;

   assign srch_ctl.clear  = accept;
   assign srch_ctl.enable = st_search;

   // control
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SEARCH;
               pos_in   = '0;
            end
         end
         ST_SEARCH: begin
            pos_in = pos_ff + IDX_W'(1);
            if (pos_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            state_in = ST_IDLE;
            if (!ovf) begin
               count_in = count_ff + CNT_W'(miss_cnt);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= st_resolve;
      end
   end

   // latch request, masked to the stored key width
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_data.operation;
         base_ff   <= count_ff;
         key_ff[0] <= req_data.vertex_a[KEY_W-1:0];
         key_ff[1] <= req_data.vertex_b[KEY_W-1:0];
         key_ff[2] <= req_data.vertex_c[KEY_W-1:0];
      end
      if (st_resolve) begin
         rsp_ff <= rsp_in;
      end
   end

   vdib_match #(
      .KEY_W (KEY_W),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_match (
      .clock    (clock),
      .reset    (reset),
      .ctl      (srch_ctl),
      .head_key (ring[0]),
      .pos      (pos_ff),
      .base     (base_ff),
      .query    (key_ff),
      .hit      (hit),
      .idx      (hit_idx)
   );

   // resolve: count misses, pack the missed keys in order a, b, c
   assign miss[0]  = !hit[0];
   assign miss[1]  = !hit[1];
   assign miss[2]  = (op_ff == vdib_pkg::OP_TRIANGLE) && !hit[2];
   assign miss_cnt = {1'b0, miss[0]} + {1'b0, miss[1]} + {1'b0, miss[2]};
   assign ovf      = ({1'b0, base_ff} + (CNT_W + 1)'(miss_cnt))
                     > (CNT_W + 1)'(TABLE_DEPTH);

   assign new_key[0] = miss[0] ? key_ff[0] : (miss[1] ? key_ff[1] : key_ff[2]);
   assign new_key[1] = (miss[0] && miss[1]) ? key_ff[1] : key_ff[2];
   assign new_key[2] = key_ff[2];
   assign new_key[3] = key_ff[2];

   assign idx_a = miss[0] ? base_ff : CNT_W'(hit_idx[0]);
   assign idx_b = miss[1] ? base_ff + CNT_W'(miss[0]) : CNT_W'(hit_idx[1]);
   assign idx_c = miss[2] ? base_ff + CNT_W'(miss[0]) + CNT_W'(miss[1])
                          : CNT_W'(hit_idx[2]);

   always_comb begin
      rsp_in = '0;
      if (ovf) begin
         rsp_in.overflow = 1'b1;
      end else begin
         rsp_in.index_a     = vdib_pkg::IDX_OUT_W'(idx_a);
         rsp_in.index_b     = vdib_pkg::IDX_OUT_W'(idx_b);
         rsp_in.index_c     = (op_ff == vdib_pkg::OP_TRIANGLE)
                              ? vdib_pkg::IDX_OUT_W'(idx_c) : '0;
         rsp_in.new_entries = miss_cnt;
      end
   end

   // ring of cells: rotate during search, append new keys at resolve
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      localparam int NXT = (i + 1) % TABLE_DEPTH;
      logic [CNT_W-1:0] offset;
      logic             wr_en;

      assign offset = CNT_W'(i) - base_ff;
      assign wr_en  = st_resolve && !ovf && (offset < CNT_W'(miss_cnt));

      vdib_cell #(
         .KEY_W (KEY_W)
      ) u_cell (
         .clock     (clock),
         .shift_en  (st_search),
         .shift_key (ring[NXT]),
         .wr_en     (wr_en),
         .wr_key    (new_key[offset[1:0]]),
         .key       (ring[i])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // the table never holds more entries than it has cells
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // a response strobe follows only the resolve cycle
   a_rsp_after_resolve: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(st_resolve))
      else $error("response without resolve");

   // an overflow leaves the table untouched
   a_ovf_no_append: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.overflow |-> count_ff == $past(count_ff))
      else $error("entry count moved on overflow");

   // the count grows by exactly the reported number of new entries
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.overflow
      |-> count_ff == $past(count_ff) + CNT_W'(rsp_ff.new_entries))
      else $error("entry count does not match new entries");

   // an accepted request starts a search from the ring head
   a_accept_search: assert property (@(posedge clock) disable iff (reset)
      accept |=> st_search && pos_ff == '0)
      else $error("search did not start after accept");

endmodule
